FILE: rtl/rau_pkg.sv
// Shared types, operation and status codes, and helpers for the rational arithmetic unit.
`default_nettype none

package rau_pkg;

   localparam int WIDTH = 32;

   typedef logic [WIDTH-1:0] word_type;

   localparam logic [1:0] KIND_ADD = 2'd0;
   localparam logic [1:0] KIND_SUB = 2'd1;
   localparam logic [1:0] KIND_MUL = 2'd2;
   localparam logic [1:0] KIND_DIV = 2'd3;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DEN = 2'd2;

   // Magnitude of a two's complement word; the most negative value maps to 2^(WIDTH-1).
   function automatic word_type magnitude(input word_type v);
      magnitude = v[WIDTH-1] ? (~v + word_type'(1)) : v;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/rau_divider.sv
// Restoring unsigned divider, one quotient bit per cycle, shared by gcd and reduction.
`default_nettype none

module rau_divider (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire rau_pkg::word_type dividend,
   input  wire rau_pkg::word_type divisor,
   output logic                   done,
   output rau_pkg::word_type      quotient,
   output rau_pkg::word_type      remainder
);
   import rau_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   word_type         rem_ff, rem_in;
   word_type         quo_ff, quo_in;
   word_type         div_ff, div_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
         end else begin
            rem_in = shifted[WIDTH-1:0];
         end
         quo_in = {quo_ff[WIDTH-2:0], ~diff[WIDTH]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider finished without running");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start) else $error("divider restarted while busy");
   a_busy_clears: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider still busy when done");

endmodule

`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer, shared multiplier and gcd reduction.
`default_nettype none

// The unit takes one item on the req_ channel: an operation code and two signed
// fractions, plus a flag asking for reduction to lowest terms. It answers with one
// item on the rsp_ channel: numerator, denominator and a status code. Arithmetic
// wraps to 32 bits.
// An item is taken when req_valid is high and req_stall is low. req_stall stays
// high from the cycle after acceptance until the result has been taken, so only
// one item is in flight at a time.
// Work goes through a single 32 by 32 multiplier (low half kept) and a
// one-bit-per-cycle divider. Reduction adds one division per step of the Euclid
// loop plus two more to divide both terms by the gcd, each issued from its own
// state before the wait for its result. Small terms need a step or two;
// full-width random terms need about 19 steps, and the longest loop, on
// consecutive Fibonacci terms, about 45 steps.
// Subtraction and division perform two builds back to back.
// The result is held in output registers with rsp_valid high until rsp_stall is
// low; a stalled result does not change. Reset returns the sequencer to idle and
// drops any item in progress.

module rational_arithmetic_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [1:0]                     req_kind,
   input  wire logic signed [rau_pkg::WIDTH-1:0] req_a_num,
   input  wire logic signed [rau_pkg::WIDTH-1:0] req_a_den,
   input  wire logic signed [rau_pkg::WIDTH-1:0] req_b_num,
   input  wire logic signed [rau_pkg::WIDTH-1:0] req_b_den,
   input  wire logic                           req_reduce_request,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [rau_pkg::WIDTH-1:0]      rsp_res_num,
   output logic signed [rau_pkg::WIDTH-1:0]      rsp_res_den,
   output logic [1:0]                          rsp_status
);
   import rau_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_CHECK,
      ST_GCD,
      ST_GCD_WAIT,
      ST_QN,
      ST_QN_WAIT,
      ST_QD,
      ST_QD_WAIT,
      ST_NEXT,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] kind_ff, kind_in;
   logic       red_ff, red_in;        // reduction asked for by the item
   logic       red_eff_ff, red_eff_in; // reduction applied to the current build
   logic       first_ff, first_in;    // a second build follows this one
   logic [1:0] step_ff, step_in;
   word_type   an_ff, an_in;
   word_type   ad_ff, ad_in;
   word_type   bn_ff, bn_in;
   word_type   bd_ff, bd_in;
   word_type   fn_ff, fn_in;
   word_type   fd_ff, fd_in;
   word_type   tmp_ff, tmp_in;
   word_type   gx_ff, gx_in;
   word_type   gy_ff, gy_in;
   word_type   res_num_ff, res_num_in;
   word_type   res_den_ff, res_den_in;
   logic [1:0] status_ff, status_in;

   logic                 accept;
   logic                 is_add;
   word_type             mul_x;
   word_type             mul_y;
   word_type             mul_lo;
   logic                 div_start;
   word_type             div_dividend;
   word_type             div_divisor;
   logic                 div_done;
   word_type             div_quo;
   word_type             div_rem;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign is_add    = (kind_ff == KIND_ADD) || (kind_ff == KIND_SUB);

   // Operand selection for the shared multiplier. A sum needs an*bd, bn*ad and ad*bd;
   // a product needs an*bn and ad*bd.
   always_comb begin
      mul_x = an_ff;
      mul_y = bn_ff;
      case (step_ff)
         2'd0: begin
            mul_x = an_ff;
            mul_y = is_add ? bd_ff : bn_ff;
         end
         2'd1: begin
            mul_x = is_add ? bn_ff : ad_ff;
            mul_y = is_add ? ad_ff : bd_ff;
         end
         default: begin
            mul_x = ad_ff;
            mul_y = bd_ff;
         end
      endcase
   end

   // Only the low word of the product is needed, as the terms wrap.
   assign mul_lo = mul_x * mul_y;

   // The divider serves the Euclid loop and then the two divisions by the gcd.
   always_comb begin
      div_start    = 1'b0;
      div_dividend = gx_ff;
      div_divisor  = gy_ff;
      case (state_ff)
         ST_GCD: begin
            div_start = (gy_ff != '0);
         end
         ST_QN: begin
            div_start    = 1'b1;
            div_dividend = magnitude(fn_ff);
            div_divisor  = gx_ff;
         end
         ST_QD: begin
            div_start    = 1'b1;
            div_dividend = magnitude(fd_ff);
            div_divisor  = gx_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   rau_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      red_in     = red_ff;
      red_eff_in = red_eff_ff;
      first_in   = first_ff;
      step_in    = step_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      bn_in      = bn_ff;
      bd_in      = bd_ff;
      fn_in      = fn_ff;
      fd_in      = fd_ff;
      tmp_in     = tmp_ff;
      gx_in      = gx_ff;
      gy_in      = gy_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      status_in  = status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_kind;
               red_in   = req_reduce_request;
               an_in    = $unsigned(req_a_num);
               ad_in    = $unsigned(req_a_den);
               bn_in    = $unsigned(req_b_num);
               bd_in    = $unsigned(req_b_den);
               step_in  = 2'd0;
               first_in = 1'b0;
               case (req_kind)
                  KIND_SUB: begin
                     // Negate the second fraction first, always reduced.
                     fn_in      = word_type'(0) - $unsigned(req_b_num);
                     fd_in      = $unsigned(req_b_den);
                     red_eff_in = 1'b1;
                     first_in   = 1'b1;
                     state_in   = ST_CHECK;
                  end
                  KIND_DIV: begin
                     if (req_b_num == '0) begin
                        res_num_in = '0;
                        res_den_in = '0;
                        status_in  = STATUS_DIV_ZERO;
                        state_in   = ST_DONE;
                     end else begin
                        // Invert the divisor first.
                        fn_in      = $unsigned(req_b_den);
                        fd_in      = $unsigned(req_b_num);
                        red_eff_in = req_reduce_request;
                        first_in   = 1'b1;
                        state_in   = ST_CHECK;
                     end
                  end
                  default: begin
                     red_eff_in = req_reduce_request;
                     state_in   = ST_MUL;
                  end
               endcase
            end
         end

         ST_MUL: begin
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0: begin
                  fn_in = mul_lo;
               end
               2'd1: begin
                  if (is_add) begin
                     tmp_in = mul_lo;
                  end else begin
                     fd_in    = mul_lo;
                     state_in = ST_CHECK;
                  end
               end
               default: begin
                  fd_in    = mul_lo;
                  state_in = ST_SUM;
               end
            endcase
         end

         ST_SUM: begin
            fn_in    = fn_ff + tmp_ff;
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (fd_ff == '0) begin
               res_num_in = '0;
               res_den_in = '0;
               status_in  = STATUS_ZERO_DEN;
               state_in   = ST_DONE;
            end else if (red_eff_ff) begin
               gx_in    = magnitude(fn_ff);
               gy_in    = magnitude(fd_ff);
               state_in = ST_GCD;
            end else begin
               state_in = ST_NEXT;
            end
         end

         ST_GCD: begin
            // When the remainder reaches zero, gx holds the gcd magnitude.
            if (gy_ff == '0) begin
               state_in = ST_QN;
            end else begin
               state_in = ST_GCD_WAIT;
            end
         end

         ST_GCD_WAIT: begin
            if (div_done) begin
               gx_in    = gy_ff;
               gy_in    = div_rem;
               state_in = ST_GCD;
            end
         end

         ST_QN: begin
            state_in = ST_QN_WAIT;
         end

         ST_QN_WAIT: begin
            if (div_done) begin
               // The gcd carries the sign of the denominator.
               fn_in    = (fn_ff[WIDTH-1] != fd_ff[WIDTH-1]) ? (word_type'(0) - div_quo)
                                                             : div_quo;
               state_in = ST_QD;
            end
         end

         ST_QD: begin
            state_in = ST_QD_WAIT;
         end

         ST_QD_WAIT: begin
            if (div_done) begin
               // Denominator and gcd share a sign, so the quotient is positive.
               fd_in    = div_quo;
               state_in = ST_NEXT;
            end
         end

         ST_NEXT: begin
            if (first_ff) begin
               bn_in      = fn_ff;
               bd_in      = fd_ff;
               first_in   = 1'b0;
               step_in    = 2'd0;
               red_eff_in = (kind_ff == KIND_SUB) ? 1'b1 : red_ff;
               state_in   = ST_MUL;
            end else begin
               res_num_in = fn_ff;
               res_den_in = fd_ff;
               status_in  = STATUS_OK;
               state_in   = ST_DONE;
            end
         end

         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff    <= kind_in;
      red_ff     <= red_in;
      red_eff_ff <= red_eff_in;
      first_ff   <= first_in;
      step_ff    <= step_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      bn_ff      <= bn_in;
      bd_ff      <= bd_in;
      fn_ff      <= fn_in;
      fd_ff      <= fd_in;
      tmp_ff     <= tmp_in;
      gx_ff      <= gx_in;
      gy_ff      <= gy_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      status_ff  <= status_in;
   end

   assign rsp_valid   = (state_ff == ST_DONE);
   assign rsp_res_num = $signed(res_num_ff);
   assign rsp_res_den = $signed(res_den_ff);
   assign rsp_status  = status_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && !req_stall)) else $error("input taken while a result is pending");
   a_error_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_res_num == '0 && rsp_res_den == '0))
      else $error("error result carries non-zero terms");
   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_GCD_WAIT || state_ff == ST_QN_WAIT ||
                    state_ff == ST_QD_WAIT))
      else $error("divider result arrived outside a wait state");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall) else $error("sequencer did not leave idle after accepting");
   a_ok_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OK) |-> (rsp_res_den != '0))
      else $error("successful result with zero denominator");

endmodule

`default_nettype wire
